// ===== sv/daes_pkg.sv =====
package daes_pkg;

  localparam int unsigned BlkW  = 128;
  localparam int unsigned HalfW = 64;
  localparam int unsigned Rnds  = 10;
  localparam int unsigned CfgIdxW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY1_HI = 8'd0,
    REG_KEY1_LO = 8'd1,
    REG_IV1_HI  = 8'd2,
    REG_IV1_LO  = 8'd3,
    REG_KEY2_HI = 8'd4,
    REG_KEY2_LO = 8'd5,
    REG_IV2_HI  = 8'd6,
    REG_IV2_LO  = 8'd7
  } cfg_reg_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [Rnds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte 0 sits in the top bits
  function automatic logic [7:0] get_byte(logic [BlkW-1:0] v, int unsigned i);
    return v[BlkW-1-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [BlkW-1:0] sub_shift(logic [BlkW-1:0] s);
    logic [BlkW-1:0] t;
    t = '0;
    for (int unsigned c = 0; c < 4; c++) begin
      for (int unsigned i = 0; i < 4; i++) begin
        t[BlkW-1-8*(c*4+i) -: 8] = SBOX[get_byte(s, ((c + i) % 4) * 4 + i)];
      end
    end
    return t;
  endfunction

  function automatic logic [BlkW-1:0] mix_cols(logic [BlkW-1:0] s);
    logic [BlkW-1:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int unsigned c = 0; c < 4; c++) begin
      a0  = get_byte(s, c*4);
      a1  = get_byte(s, c*4+1);
      a2  = get_byte(s, c*4+2);
      a3  = get_byte(s, c*4+3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[BlkW-1-8*(c*4)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[BlkW-1-8*(c*4+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[BlkW-1-8*(c*4+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[BlkW-1-8*(c*4+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  function automatic logic [BlkW-1:0] next_key(logic [BlkW-1:0] k, logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ===== sv/daes_cipher.sv =====
module daes_cipher
  import daes_pkg::*;
(
  input  logic [BlkW-1:0] key_i,
  input  logic [BlkW-1:0] blk_i,
  output logic [BlkW-1:0] ks_o
);

  logic [BlkW-1:0] rk [Rnds+1];
  logic [BlkW-1:0] st [Rnds+1];

  assign rk[0] = key_i;
  assign st[0] = blk_i ^ key_i;

  for (genvar r = 1; r <= Rnds; r++) begin : g_rnd
    logic [BlkW-1:0] sb;
    assign rk[r] = next_key(rk[r-1], RCON[r-1]);
    assign sb    = sub_shift(st[r-1]);
    if (r == Rnds) begin : g_last
      assign st[r] = sb ^ rk[r];
    end else begin : g_mid
      assign st[r] = mix_cols(sb) ^ rk[r];
    end
  end

  assign ks_o = st[Rnds];

endmodule

// ===== sv/dual_aes128_ctr_keystream_xor_top.sv =====
// An accepted input word is held in the input register, then its result in the result register.
// Throughput: one word per cycle while out_stall_i is low; both AES-128 ciphers run unrolled between
// the input register and the result register, so that path sets fmax.
// Reset (rst_ni low, async): config registers, both counters and the pipe
// valid bits clear; payload registers are left alone.
module dual_aes128_ctr_keystream_xor_top
  import daes_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [HalfW-1:0]   cfg_data_i,
  // input words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               region_start_i,
  input  logic [HalfW-1:0]   data_high_i,
  input  logic [HalfW-1:0]   data_low_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [HalfW-1:0]   result_high_o,
  output logic [HalfW-1:0]   result_low_o
);

  // Config registers; indices past the list are dropped.
  logic [HalfW-1:0] key1_hi_q, key1_lo_q, iv1_hi_q, iv1_lo_q;
  logic [HalfW-1:0] key2_hi_q, key2_lo_q, iv2_hi_q, iv2_lo_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key1_hi_q <= '0; key1_lo_q <= '0; iv1_hi_q <= '0; iv1_lo_q <= '0;
      key2_hi_q <= '0; key2_lo_q <= '0; iv2_hi_q <= '0; iv2_lo_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_KEY1_HI: key1_hi_q <= cfg_data_i;
        REG_KEY1_LO: key1_lo_q <= cfg_data_i;
        REG_IV1_HI:  iv1_hi_q  <= cfg_data_i;
        REG_IV1_LO:  iv1_lo_q  <= cfg_data_i;
        REG_KEY2_HI: key2_hi_q <= cfg_data_i;
        REG_KEY2_LO: key2_lo_q <= cfg_data_i;
        REG_IV2_HI:  iv2_hi_q  <= cfg_data_i;
        REG_IV2_LO:  iv2_lo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipe control: stage 1 = input register, stage 2 = result register.
  logic s1_valid_q, s2_valid_q;
  logic s2_load, s1_load, in_acc;

  assign s2_load    = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s2_load;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s1_load    = in_acc;

  // Counters: pick IV on region start, store value+1 for the next word.
  logic [BlkW-1:0] ctr1_q, ctr2_q, ctr1_d, ctr2_d;
  logic [BlkW-1:0] cur1, cur2;

  assign cur1   = region_start_i ? {iv1_hi_q, iv1_lo_q} : ctr1_q;
  assign cur2   = region_start_i ? {iv2_hi_q, iv2_lo_q} : ctr2_q;
  assign ctr1_d = cur1 + BlkW'(1);
  assign ctr2_d = cur2 + BlkW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr1_q     <= '0;
      ctr2_q     <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        ctr1_q <= ctr1_d;
        ctr2_q <= ctr2_d;
      end
      if (s1_load)      s1_valid_q <= 1'b1;
      else if (s2_load) s1_valid_q <= 1'b0;
      if (s2_load)                  s2_valid_q <= 1'b1;
      else if (!out_stall_i)        s2_valid_q <= 1'b0;
    end
  end

  // Stage 1 payload
  logic [BlkW-1:0] s1_data_q, s1_ctr1_q, s1_ctr2_q;

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_data_q <= {data_high_i, data_low_i};
      s1_ctr1_q <= cur1;
      s1_ctr2_q <= cur2;
    end
  end

  // Two keystream blocks, keys straight from config (user keeps them stable while busy; not enforced).
  logic [BlkW-1:0] ks1, ks2, res_d, res_q;

  daes_cipher u_cipher1 (
    .key_i ({key1_hi_q, key1_lo_q}),
    .blk_i (s1_ctr1_q),
    .ks_o  (ks1)
  );

  daes_cipher u_cipher2 (
    .key_i ({key2_hi_q, key2_lo_q}),
    .blk_i (s1_ctr2_q),
    .ks_o  (ks2)
  );

  assign res_d = s1_data_q ^ ks1 ^ ks2;

  always_ff @(posedge clk_i) begin
    if (s2_load) res_q <= res_d;
  end

  assign out_valid_o   = s2_valid_q;
  assign result_high_o = res_q[BlkW-1:HalfW];
  assign result_low_o  = res_q[HalfW-1:0];

endmodule

// ===== sv/daes_checker.sv =====
module daes_checker
  import daes_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_valid_i,
  input logic             cfg_ready_o,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [HalfW-1:0] result_high_o,
  input logic [HalfW-1:0] result_low_o
);

  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(result_high_o) && $stable(result_low_o))
    else $error("stalled result word changed");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##1 out_valid_o)
    else $error("accepted word did not reach the output");

endmodule

bind dual_aes128_ctr_keystream_xor_top daes_checker u_daes_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .result_high_o (result_high_o),
  .result_low_o  (result_low_o)
);

// ===== tb/dual_aes128_ctr_keystream_xor_checker.sv =====
module dual_aes128_ctr_keystream_xor_checker
  import daes_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [HalfW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             region_start_i,
  input  logic [HalfW-1:0] data_high_i,
  input  logic [HalfW-1:0] data_low_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [HalfW-1:0] result_high_i,
  input  logic [HalfW-1:0] result_low_i,
  output int               errors_o,
  output int               pending_o
);

  typedef struct packed {
    logic [HalfW-1:0] hi;
    logic [HalfW-1:0] lo;
  } blk_t;

  localparam logic [7:0] SB [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  logic [HalfW-1:0] regs [8];
  logic [BlkW-1:0]  ctr_a, ctr_b;
  blk_t             expected_q [$];
  int               errors;
  int               pending;

  function automatic logic [7:0] gmul2(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte array view: s[0], t[0] and k[0] hold the top byte
  function automatic logic [BlkW-1:0] cipher(logic [BlkW-1:0] key, logic [BlkW-1:0] pt);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] k [16];
    logic [7:0] rc, tmp, x;
    logic [BlkW-1:0] res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      k[i] = key[127-8*i -: 8];
      s[i] = pt[127-8*i -: 8] ^ k[i];
    end
    for (int r = 1; r <= 10; r++) begin
      // next round key
      tmp = k[12];
      k[0] = k[0] ^ SB[k[13]] ^ rc;
      k[1] = k[1] ^ SB[k[14]];
      k[2] = k[2] ^ SB[k[15]];
      k[3] = k[3] ^ SB[tmp];
      for (int i = 4; i < 16; i++) k[i] = k[i] ^ k[i-4];
      rc = gmul2(rc);
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[c*4+i] = SB[s[((c+i)%4)*4+i]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          x = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
          tmp = t[c*4];
          t[c*4]   = t[c*4]   ^ x ^ gmul2(t[c*4]   ^ t[c*4+1]);
          t[c*4+1] = t[c*4+1] ^ x ^ gmul2(t[c*4+1] ^ t[c*4+2]);
          t[c*4+2] = t[c*4+2] ^ x ^ gmul2(t[c*4+2] ^ t[c*4+3]);
          t[c*4+3] = t[c*4+3] ^ x ^ gmul2(t[c*4+3] ^ tmp);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ k[i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [HalfW-1:0] got, logic [HalfW-1:0] exp);
    $display("mismatch %s: got %h exp %h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  assign errors_o  = errors;
  assign pending_o = pending;

  always @(posedge clk_i or negedge rst_ni) begin
    logic [BlkW-1:0] ks;
    blk_t            e;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) regs[i] = '0;
      ctr_a = '0;
      ctr_b = '0;
      expected_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < 8) regs[cfg_index_i[2:0]] = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        if (region_start_i) begin
          ctr_a = {regs[REG_IV1_HI], regs[REG_IV1_LO]};
          ctr_b = {regs[REG_IV2_HI], regs[REG_IV2_LO]};
        end
        ks = cipher({regs[REG_KEY1_HI], regs[REG_KEY1_LO]}, ctr_a)
           ^ cipher({regs[REG_KEY2_HI], regs[REG_KEY2_LO]}, ctr_b);
        e = {data_high_i, data_low_i} ^ ks;
        expected_q.push_back(e);
        ctr_a = ctr_a + 1'b1;
        ctr_b = ctr_b + 1'b1;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", result_high_i, '0);
        end else begin
          e = expected_q.pop_front();
          if (result_high_i !== e.hi) report_mismatch("result_high", result_high_i, e.hi);
          if (result_low_i !== e.lo) report_mismatch("result_low", result_low_i, e.lo);
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

// ===== tb/dual_aes128_ctr_keystream_xor_top_tb.sv =====
module dual_aes128_ctr_keystream_xor_top_tb;
  import daes_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [HalfW-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               region_start_i;
  logic [HalfW-1:0]   data_high_i;
  logic [HalfW-1:0]   data_low_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [HalfW-1:0]   result_high_o;
  logic [HalfW-1:0]   result_low_o;
  int                 errors;
  int                 pending;
  bit                 calm;        // no idling in the last stretch

  dual_aes128_ctr_keystream_xor_top DUT (.*);

  dual_aes128_ctr_keystream_xor_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .region_start_i, .data_high_i, .data_low_i,
    .out_valid_i(out_valid_o), .out_stall_i, .result_high_i(result_high_o),
    .result_low_i(result_low_o), .errors_o(errors), .pending_o(pending)
  );

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // Result-side stall: bursts of random length, with quiet stretches between.
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 3);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Send one config word; waits for ready, then drops valid and idles.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [HalfW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every word has come back, then let the pipe drain.
  task automatic settle();
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Load all eight registers; mode picks zeros, ones or random content.
  task automatic load_all(int mode);
    logic [HalfW-1:0] v;
    for (int i = 0; i < 8; i++) begin
      case (mode)
        0: v = '0;
        1: v = '1;
        default: v = {$urandom, $urandom};
      endcase
      write_reg(cfg_reg_e'(i), v);
    end
  endtask

  // One input word, with an optional random gap before it.
  task automatic send_word(logic start, logic [HalfW-1:0] hi, logic [HalfW-1:0] lo);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    region_start_i <= start;
    data_high_i    <= hi;
    data_low_i     <= lo;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_idle();
    in_valid_i <= 1'b0;
  endtask

  initial begin
    logic [HalfW-1:0] near_top;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    region_start_i = 1'b0;
    data_high_i    = '0;
    data_low_i     = '0;
    calm           = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: counters straight out of reset, no region start yet.
    send_word(1'b0, '0, '0);
    send_word(1'b0, '1, '1);
    send_word(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_idle();
    settle();

    // All-ones keys and IVs: counter wraps from all ones to zero.
    load_all(1);
    send_word(1'b1, '0, '0);
    send_word(1'b0, '1, '1);
    send_word(1'b0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    send_word(1'b1, '0, '1);
    send_idle();
    settle();

    // Carry from the low half into the high half of each counter.
    write_reg(REG_IV1_HI, 64'h0000_0000_0000_0007);
    write_reg(REG_IV1_LO, '1);
    write_reg(REG_IV2_HI, '0);
    write_reg(REG_IV2_LO, 64'hffff_ffff_ffff_fffe);
    for (int i = 0; i < 4; i++) send_word(i == 0, {$urandom, $urandom}, {$urandom, $urandom});
    send_idle();
    settle();
    // out-of-range index must be ignored
    write_reg(8'hff, 64'hdead_beef_dead_beef);
    write_reg(8'd8, '1);
    send_word(1'b1, '0, '0);
    send_idle();
    settle();

    // Zero config with a region start; same key and IV on both sides, so the keystreams cancel.
    load_all(0);
    send_word(1'b1, '1, '0);
    send_word(1'b0, '0, '1);
    send_idle();
    settle();

    // Random phases: random config, regions of random length.
    for (int ph = 0; ph < 8; ph++) begin
      load_all(2);
      if (ph == 3) begin
        near_top = '1;
        write_reg(REG_IV1_LO, near_top - $urandom_range(0, 20));
        write_reg(REG_IV2_LO, near_top - $urandom_range(0, 20));
      end
      if (ph == 7) calm = 1'b1;
      for (int n = 0; n < 215; n++) begin
        send_word(n == 0 || $urandom_range(0, 24) == 0,
                  {$urandom, $urandom}, {$urandom, $urandom});
      end
      send_idle();
      settle();
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("dual_aes128_ctr_keystream_xor_top regression: pass");
    else $display("dual_aes128_ctr_keystream_xor_top regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("dual_aes128_ctr_keystream_xor_top regression: fail");
    $finish;
  end

endmodule
